/* rtl/spm_pkg.sv */
// Package for the streaming string pattern matcher.
// Register indexes, match mode codes, fixed field widths and shared types.
// No dependencies.
package spm_pkg;

    localparam int BYTE_W        = 8;
    localparam int WORD_W        = 64;
    localparam int PATTERN_BYTES = 32;
    localparam int PATTERN_WORDS = 4;
    localparam int MODE_W        = 2;
    localparam int LEN_W         = 6;
    localparam int CFG_IDX_W     = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_3 = 3'd5;

    // match modes
    localparam logic [MODE_W-1:0] MODE_EXACT     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PREFIX    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SUFFIX    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SUBSTRING = 2'd3;

    typedef logic [BYTE_W-1:0] data_byte_t;

    // control broadcast to every window cell
    typedef struct packed {
        logic shift;    // take the neighbor's byte at this edge
        logic use_new;  // compare the incoming byte, not the held one
    } cell_ctrl_t;

endpackage

/* rtl/spm_ifs.sv */
// Stream interfaces of the string pattern matcher: text input and result output.
// Depends on spm_pkg for the byte type.
interface spm_in_if;
    logic                valid;
    logic                ready;
    spm_pkg::data_byte_t text_byte;
    logic                empty_string;
    logic                string_end;

    modport source (output valid, output text_byte, output empty_string,
                    output string_end, input ready);
    modport sink   (input valid, input text_byte, input empty_string,
                    input string_end, output ready);
endinterface

interface spm_out_if #(
    parameter int INDEX_WIDTH = 16
);
    logic                   valid;
    logic                   ready;
    logic [INDEX_WIDTH-1:0] string_index;
    logic                   matched;

    modport source (output valid, output string_index, output matched, input ready);
    modport sink   (input valid, input string_index, input matched, output ready);
endinterface

/* rtl/spm_cell.sv */
// One cell of the tail window: holds one text byte, passes it on each shift,
// and compares the byte it currently presents against its aligned pattern byte.
// Depends on spm_pkg.
module spm_cell (
    input  logic                clk,
    input  spm_pkg::cell_ctrl_t ctrl,
    input  spm_pkg::data_byte_t left_byte,
    input  spm_pkg::data_byte_t pat_byte,
    input  logic                active,
    output spm_pkg::data_byte_t byte_out,
    output logic                eq
);

    spm_pkg::data_byte_t win_reg;
    spm_pkg::data_byte_t win_next;
    spm_pkg::data_byte_t cur_byte;

    assign win_next = left_byte;
    assign cur_byte = ctrl.use_new ? left_byte : win_reg;
    // cells beyond the pattern length always agree
    assign eq       = !active || (cur_byte == pat_byte);
    assign byte_out = win_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            win_reg <= win_next;
        end
    end

endmodule

/* rtl/spm_out_buf.sv */
// Two-entry result buffer (output register plus skid) for the matcher.
// Depends on spm_out_if.
module spm_out_buf #(
    parameter int INDEX_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [INDEX_WIDTH-1:0] push_index,
    input  logic                   push_matched,
    output logic                   full,
    spm_out_if.source              out_ch
);

    logic                   out_valid_reg, out_valid_next;
    logic [INDEX_WIDTH-1:0] out_index_reg, out_index_next;
    logic                   out_match_reg, out_match_next;
    logic                   skid_valid_reg, skid_valid_next;
    logic [INDEX_WIDTH-1:0] skid_index_reg, skid_index_next;
    logic                   skid_match_reg, skid_match_next;
    logic                   pop;

    assign pop = out_valid_reg && out_ch.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_index_next  = out_index_reg;
        out_match_next  = out_match_reg;
        skid_valid_next = skid_valid_reg;
        skid_index_next = skid_index_reg;
        skid_match_next = skid_match_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_index_next  = skid_index_reg;
                out_match_next  = skid_match_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_index_next = push_index;
                out_match_next = push_matched;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_index_next = push_index;
                out_match_next = push_matched;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_index_next = push_index;
                skid_match_next = push_matched;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_index_reg  <= out_index_next;
        out_match_reg  <= out_match_next;
        skid_index_reg <= skid_index_next;
        skid_match_reg <= skid_match_next;
    end

    assign full                = skid_valid_reg;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.string_index = out_index_reg;
    assign out_ch.matched      = out_match_reg;

endmodule

/* rtl/string_pattern_matcher.sv */
// Streaming string pattern matcher. Text bytes arrive one per request on in_ch;
// the request flagged string_end closes the current string and yields one result
// on out_ch: the string's running index (wraps at INDEX_WIDTH bits) and a match
// flag for the mode in match_mode (exact, prefix, suffix, substring). A request
// with empty_string set carries no byte. The block takes one request per clock
// while in_ch.ready is high; a closing request's result is registered in the
// result buffer as the request is taken. The rate is set by the tail window: a
// row of PATTERN_MAX byte cells shifting together, each comparing its byte with
// the pattern byte aligned to it, all in the same cycle. Results sit in a
// two-entry buffer, so input keeps flowing while one result waits; in_ch.ready
// drops only when both entries hold untaken results. Configuration writes take
// effect on the next request; pattern bytes at or beyond position 32 read as
// zero, and a length above PATTERN_MAX counts as PATTERN_MAX.
// Depends on spm_pkg, spm_ifs, spm_cell and spm_out_buf.
module string_pattern_matcher #(
    parameter int PATTERN_MAX = 32,
    parameter int INDEX_WIDTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    spm_in_if.sink                           in_ch,
    spm_out_if.source                        out_ch,
    input  logic                             cfg_we,
    input  logic [spm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spm_pkg::WORD_W-1:0]       cfg_data
);

    localparam int CW    = $clog2(PATTERN_MAX + 2);       // bytes_seen, lengths
    localparam int CMP_W = (CW > spm_pkg::LEN_W) ? CW : spm_pkg::LEN_W;
    localparam int PV_W  = spm_pkg::BYTE_W * PATTERN_MAX;  // pattern vector

    // ---------------- configuration registers ----------------
    logic [spm_pkg::MODE_W-1:0] mode_reg;
    logic [spm_pkg::LEN_W-1:0]  plen_reg;
    logic [spm_pkg::PATTERN_WORDS-1:0][spm_pkg::WORD_W-1:0] pat_words_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= spm_pkg::MODE_PREFIX;
            plen_reg      <= '0;
            pat_words_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                spm_pkg::REG_MATCH_MODE:     mode_reg <= cfg_data[spm_pkg::MODE_W-1:0];
                spm_pkg::REG_PATTERN_LENGTH: plen_reg <= cfg_data[spm_pkg::LEN_W-1:0];
                spm_pkg::REG_PATTERN_WORD_0: pat_words_reg[0] <= cfg_data;
                spm_pkg::REG_PATTERN_WORD_1: pat_words_reg[1] <= cfg_data;
                spm_pkg::REG_PATTERN_WORD_2: pat_words_reg[2] <= cfg_data;
                spm_pkg::REG_PATTERN_WORD_3: pat_words_reg[3] <= cfg_data;
                default: ;  // unknown index: dropped
            endcase
        end
    end

    // effective length, clamped to the window depth
    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] len_clamp;
    logic [CW-1:0]    len_eff;

    assign len_ext   = CMP_W'(plen_reg);
    assign len_clamp = (len_ext > CMP_W'(PATTERN_MAX)) ? CMP_W'(PATTERN_MAX) : len_ext;
    assign len_eff   = len_clamp[CW-1:0];

    // pattern as a byte vector (byte i at bits 8i), plus its byte reversal
    logic [PV_W-1:0] pat_vec;
    logic [PV_W-1:0] rev_vec;
    logic [PV_W-1:0] aligned_vec;   // byte k = pattern byte len-1-k
    logic [CW-1:0]   align_shamt;

    for (genvar i = 0; i < PATTERN_MAX; i++)
    begin : g_pat
        if (i < spm_pkg::PATTERN_BYTES)
        begin : g_live
            assign pat_vec[spm_pkg::BYTE_W*i +: spm_pkg::BYTE_W] =
                pat_words_reg[i / 8][spm_pkg::BYTE_W*(i % 8) +: spm_pkg::BYTE_W];
        end
        else
        begin : g_zero
            assign pat_vec[spm_pkg::BYTE_W*i +: spm_pkg::BYTE_W] = '0;
        end
        assign rev_vec[spm_pkg::BYTE_W*i +: spm_pkg::BYTE_W] =
            pat_vec[spm_pkg::BYTE_W*(PATTERN_MAX-1-i) +: spm_pkg::BYTE_W];
    end

    assign align_shamt = CW'(PATTERN_MAX) - len_eff;
    assign aligned_vec = rev_vec >> {align_shamt, 3'b000};

    // ---------------- per-string state ----------------
    logic [CW-1:0]   seen_reg, seen_next, seen_cur;
    logic            pok_reg, pok_next, pok_cur;
    logic            sub_reg, sub_next, sub_cur;
    logic [INDEX_WIDTH-1:0] count_reg, count_next;

    logic accept;
    logic has_byte;
    logic buf_full;
    logic [PV_W-1:0] pref_vec;
    spm_pkg::data_byte_t pref_byte;

    assign accept   = in_ch.valid && in_ch.ready;
    assign has_byte = !in_ch.empty_string;
    assign in_ch.ready = !buf_full;

    // pattern byte at the current position, for the prefix test
    assign pref_vec  = pat_vec >> {seen_reg, 3'b000};
    assign pref_byte = pref_vec[spm_pkg::BYTE_W-1:0];

    // ---------------- window cell row ----------------
    spm_pkg::cell_ctrl_t ctrl;
    spm_pkg::data_byte_t chain [PATTERN_MAX+1];
    logic [PATTERN_MAX-1:0] cell_eq;
    logic win_ok;

    assign ctrl.shift   = accept && has_byte;
    assign ctrl.use_new = has_byte;
    assign chain[0]     = in_ch.text_byte;

    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        logic active;
        assign active = (CW'(k) < len_eff);
        spm_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .left_byte (chain[k]),
            .pat_byte  (aligned_vec[spm_pkg::BYTE_W*k +: spm_pkg::BYTE_W]),
            .active    (active),
            .byte_out  (chain[k+1]),
            .eq        (cell_eq[k])
        );
    end

    // latest len bytes equal the pattern (window including this request's byte)
    assign win_ok = &cell_eq;

    // ---------------- per-request update ----------------
    logic matched;

    always_comb
    begin
        seen_cur = seen_reg;
        pok_cur  = pok_reg;
        if (has_byte)
        begin
            if ((seen_reg < len_eff) && (in_ch.text_byte != pref_byte))
            begin
                pok_cur = 1'b0;
            end
            if (seen_reg <= CW'(PATTERN_MAX))
            begin
                seen_cur = seen_reg + 1'b1;
            end
        end
        sub_cur = sub_reg ||
                  (has_byte && (len_eff != '0) && (seen_cur >= len_eff) && win_ok);

        case (mode_reg)
            spm_pkg::MODE_EXACT:  matched = (seen_cur == len_eff) && pok_cur;
            spm_pkg::MODE_PREFIX: matched = (seen_cur >= len_eff) && pok_cur;
            spm_pkg::MODE_SUFFIX: matched = (len_eff == '0) ||
                                            ((seen_cur >= len_eff) && win_ok);
            default:              matched = (len_eff == '0) || sub_cur;
        endcase

        seen_next  = seen_reg;
        pok_next   = pok_reg;
        sub_next   = sub_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (in_ch.string_end)
            begin
                // window bytes need no clearing: only bytes of the new string
                // are ever compared, since seen restarts at zero
                seen_next  = '0;
                pok_next   = 1'b1;
                sub_next   = 1'b0;
                count_next = count_reg + 1'b1;
            end
            else
            begin
                seen_next = seen_cur;
                pok_next  = pok_cur;
                sub_next  = sub_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            pok_reg   <= 1'b1;
            sub_reg   <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            seen_reg  <= seen_next;
            pok_reg   <= pok_next;
            sub_reg   <= sub_next;
            count_reg <= count_next;
        end
    end

    // ---------------- result buffer ----------------
    spm_out_buf #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (accept && in_ch.string_end),
        .push_index   (count_reg),
        .push_matched (matched),
        .full         (buf_full),
        .out_ch       (out_ch)
    );

endmodule

/* rtl/spm_checker.sv */
// Port-level checks for string_pattern_matcher, attached by the bind below.
// Depends on the top level's ports only.
module spm_checker #(
    parameter int INDEX_WIDTH = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   in_end,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [INDEX_WIDTH-1:0] out_index,
    input logic                   out_matched
);

    logic                   in_acc;
    logic                   out_acc;
    logic [2:0]             pend_reg, pend_next;
    logic                   seen_reg;
    logic [INDEX_WIDTH-1:0] last_reg;

    assign in_acc  = in_valid && in_ready && in_end;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg + {2'b00, in_acc} - {2'b00, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            seen_reg <= 1'b0;
            last_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (out_acc)
            begin
                seen_reg <= 1'b1;
                last_reg <= out_index;
            end
        end
    end

    // a shown result always stems from a closed string not yet delivered
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pend_reg != 3'd0))
        else $error("result shown with no closed string pending");

    // at most two results are ever held
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd2)
        else $error("more results pending than the buffer holds");

    // delivered indexes run consecutively
    a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && seen_reg) |-> (out_index == last_reg + 1'b1))
        else $error("result index skipped or repeated");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result withdrawn before it was taken");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(out_index) && $stable(out_matched)))
        else $error("stalled result changed");

endmodule

bind string_pattern_matcher spm_checker #(
    .INDEX_WIDTH (INDEX_WIDTH)
) u_spm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_end      (in_ch.string_end),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_index   (out_ch.string_index),
    .out_matched (out_ch.matched)
);

/* verif/tb.sv */
// Self-checking testbench for string_pattern_matcher: random and directed text requests
// against a cycle-free predictor of the matcher. Depends on spm_pkg, spm_ifs and the RTL.
module tb;

    localparam int PAT_MAX   = 32;
    localparam int IDX_W     = 16;
    localparam int TARGET    = 1150;   // non-ignored requests to send before stopping
    localparam int SHOW_MAX  = 10;     // mismatches printed in full

    // indexes past the register list; writes there must be dropped
    localparam logic [spm_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [spm_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        spm_pkg::data_byte_t text;
        logic                no_byte;
        logic                last;
    } text_req_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             matched;
    } verdict_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                          cfg_we;
    logic [spm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [spm_pkg::WORD_W-1:0]    cfg_data;

    spm_in_if                       in_ch ();
    spm_out_if #(.INDEX_WIDTH(IDX_W)) out_ch ();

    string_pattern_matcher #(
        .PATTERN_MAX (PAT_MAX),
        .INDEX_WIDTH (IDX_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: register copies and the per-string match state
    // ------------------------------------------------------------------
    logic [spm_pkg::MODE_W-1:0] cur_mode  = spm_pkg::MODE_PREFIX;
    logic [spm_pkg::LEN_W-1:0]  cur_len   = '0;
    logic [spm_pkg::WORD_W-1:0] cur_words [spm_pkg::PATTERN_WORDS];

    spm_pkg::data_byte_t tail_win [PAT_MAX];   // [0] is the newest byte
    int               seen_cnt     = 0;     // saturates at PAT_MAX + 1
    bit               head_ok      = 1'b1;  // every leading byte equals the pattern so far
    bit               found_inside = 1'b0;  // pattern seen contiguously somewhere
    logic [IDX_W-1:0] next_index   = '0;

    // stimulus and scoreboard
    text_req_t           text_feed [$];      // requests waiting for the driver
    verdict_t            verdicts_due [$];   // predicted results, oldest first
    spm_pkg::data_byte_t draft [$];          // string under construction
    spm_pkg::data_byte_t alphabet [3];       // symbols of the current phase

    int  reqs_queued     = 0;
    int  reqs_taken      = 0;
    int  fed_items       = 0;
    int  strings_checked = 0;
    int  matched_count   = 0;
    int  mismatch_count  = 0;
    int  setting_count   = 0;
    bit  calm            = 1'b0;   // phase with no idling on either side

    bit  in_took  = 1'b0;          // request taken at the last rising edge
    bit  out_took = 1'b0;          // result taken at the last rising edge
    int  feed_gap    = 0;
    int  drain_stall = 0;

    function automatic int eff_len();
        return (cur_len > PAT_MAX) ? PAT_MAX : int'(cur_len);
    endfunction

    // pattern byte i; positions past the four words read as zero
    function automatic spm_pkg::data_byte_t pat_at(input int i);
        if (i >= spm_pkg::PATTERN_BYTES)
            return '0;
        return cur_words[i / 8][(i % 8) * 8 +: 8];
    endfunction

    // newest n bytes of the tail equal the pattern, last pattern byte newest
    function automatic bit tail_equals(input int n);
        int k;
        for (k = 0; k < n; k++)
            if (tail_win[k] != pat_at(n - 1 - k))
                return 1'b0;
        return 1'b1;
    endfunction

    // Advance the match state by one taken request; fires on a string end.
    task automatic judge_item(input text_req_t rq, output bit fires, output verdict_t v);
        int n;
        int k;
        bit hit;
        n = eff_len();
        fires = 1'b0;
        v = '0;
        if (!rq.no_byte)
        begin
            if (seen_cnt < n && rq.text != pat_at(seen_cnt))
                head_ok = 1'b0;
            for (k = PAT_MAX - 1; k > 0; k--)
                tail_win[k] = tail_win[k - 1];
            tail_win[0] = rq.text;
            if (seen_cnt <= PAT_MAX)
                seen_cnt++;
            if (n > 0 && seen_cnt >= n && tail_equals(n))
                found_inside = 1'b1;
        end
        if (rq.last)
        begin
            case (cur_mode)
                spm_pkg::MODE_EXACT:  hit = (seen_cnt == n) && head_ok;
                spm_pkg::MODE_PREFIX: hit = (seen_cnt >= n) && head_ok;
                spm_pkg::MODE_SUFFIX: hit = (n == 0) || (seen_cnt >= n && tail_equals(n));
                default:              hit = (n == 0) || found_inside;
            endcase
            fires     = 1'b1;
            v.idx     = next_index;
            v.matched = hit;
            next_index++;
            // fresh string
            for (k = 0; k < PAT_MAX; k++)
                tail_win[k] = '0;
            seen_cnt     = 0;
            head_ok      = 1'b1;
            found_inside = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input verdict_t want,
                                   input verdict_t got);
        mismatch_count++;
        if (mismatch_count <= SHOW_MAX)
            $display("mismatch (%s): expected index %0d matched %0b, got index %0d matched %0b",
                     what, want.idx, want.matched, got.idx, got.matched);
    endtask

    // ------------------------------------------------------------------
    // Monitor: both channels sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        text_req_t rq;
        verdict_t  want;
        verdict_t  got;
        bit        fires;
        if (!rst_n)
        begin
            in_took  <= 1'b0;
            out_took <= 1'b0;
        end
        else
        begin
            in_took  <= in_ch.valid && in_ch.ready;
            out_took <= out_ch.valid && out_ch.ready;
            // requests first, so an expectation is always queued ahead of its result
            if (in_ch.valid && in_ch.ready)
            begin
                rq = '{text: in_ch.text_byte, no_byte: in_ch.empty_string,
                       last: in_ch.string_end};
                judge_item(rq, fires, want);
                if (fires)
                    verdicts_due.push_back(want);
                reqs_taken++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{idx: out_ch.string_index, matched: out_ch.matched};
                if (verdicts_due.size() == 0)
                    report_mismatch("no result expected", '0, got);
                else
                begin
                    want = verdicts_due.pop_front();
                    strings_checked++;
                    if (got.matched === 1'b1)
                        matched_count++;
                    if (got.idx !== want.idx || got.matched !== want.matched)
                        report_mismatch("field", want, got);
                end
            end
        end
    end

    // idle cycles before the next request or the next result; none in a calm phase
    function automatic int draw_wait();
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    // ------------------------------------------------------------------
    // Driver: request source and result sink, both moved at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : driver
        text_req_t rq;
        if (!rst_n)
        begin
            in_ch.valid        <= 1'b0;
            in_ch.text_byte    <= '0;
            in_ch.empty_string <= 1'b0;
            in_ch.string_end   <= 1'b0;
            out_ch.ready       <= 1'b0;
        end
        else
        begin
            // a held request stays put until taken
            if (!in_ch.valid || in_took)
            begin
                if (feed_gap > 0)
                begin
                    feed_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (text_feed.size() > 0)
                begin
                    rq = text_feed.pop_front();
                    in_ch.text_byte    <= rq.text;
                    in_ch.empty_string <= rq.no_byte;
                    in_ch.string_end   <= rq.last;
                    in_ch.valid        <= 1'b1;
                    feed_gap = draw_wait();
                end
                else
                    in_ch.valid <= 1'b0;
            end
            // a new stall is drawn after each taken result
            if (out_took)
                drain_stall = draw_wait();
            if (drain_stall > 0)
            begin
                drain_stall--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_req(input spm_pkg::data_byte_t b, input bit no_byte,
                            input bit last);
        text_feed.push_back('{text: b, no_byte: no_byte, last: last});
        reqs_queued++;
        if (!no_byte || last)   // a blank non-closing request is ignored by the block
            fed_items++;
    endtask

    task automatic feed_text(input string s);
        int i;
        if (s.len() == 0)
            push_req(8'hFF, 1'b1, 1'b1);
        else
            for (i = 0; i < s.len(); i++)
                push_req(s[i], 1'b0, i == s.len() - 1);
    endtask

    // send the draft, with stray blank requests and sometimes a blank closing request
    task automatic feed_draft();
        int k;
        bit close_blank;
        if (draft.size() == 0)
        begin
            push_req(8'($urandom), 1'b1, 1'b1);
            return;
        end
        close_blank = ($urandom_range(0, 7) == 0);
        for (k = 0; k < draft.size(); k++)
        begin
            if ($urandom_range(0, 9) == 0)
                push_req(8'($urandom), 1'b1, 1'b0);
            push_req(draft[k], 1'b0, (k == draft.size() - 1) && !close_blank);
        end
        if (close_blank)
            push_req(8'($urandom), 1'b1, 1'b1);
    endtask

    // register write; only issued with nothing in flight, so the copy updates at once
    task automatic set_reg(input logic [spm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [spm_pkg::WORD_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            spm_pkg::REG_MATCH_MODE:     cur_mode     = val[spm_pkg::MODE_W-1:0];
            spm_pkg::REG_PATTERN_LENGTH: cur_len      = val[spm_pkg::LEN_W-1:0];
            spm_pkg::REG_PATTERN_WORD_0: cur_words[0] = val;
            spm_pkg::REG_PATTERN_WORD_1: cur_words[1] = val;
            spm_pkg::REG_PATTERN_WORD_2: cur_words[2] = val;
            spm_pkg::REG_PATTERN_WORD_3: cur_words[3] = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // all queued requests taken and all results back, then a settle before returning
    task automatic drain();
        wait (reqs_taken == reqs_queued && verdicts_due.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic spm_pkg::data_byte_t pick_sym();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom);
        return alphabet[$urandom_range(0, 2)];
    endfunction

    // New random setting: mode, length (extremes included) and pattern words,
    // written in a rotated order, now and then with a write past the list.
    task automatic setup_phase();
        int fill;
        int w;
        int b;
        int i;
        int start;
        int pick;
        logic [spm_pkg::WORD_W-1:0]    words [spm_pkg::PATTERN_WORDS];
        logic [spm_pkg::LEN_W-1:0]     len;
        logic [spm_pkg::CFG_IDX_W-1:0] idx;
        fill = $urandom_range(0, 5);
        for (i = 0; i < 3; i++)
            alphabet[i] = 8'($urandom);
        if (fill == 0)
            alphabet[0] = 8'h00;
        else if (fill == 1)
            alphabet[0] = 8'hFF;
        for (w = 0; w < spm_pkg::PATTERN_WORDS; w++)
            for (b = 0; b < 8; b++)
                words[w][b * 8 +: 8] = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : pick_sym();
        pick = $urandom_range(0, 9);
        case (pick)
            0:       len = '0;
            1:       len = spm_pkg::LEN_W'(PAT_MAX);
            2:       len = spm_pkg::LEN_W'($urandom_range(PAT_MAX + 1, 63));
            3, 4, 5: len = spm_pkg::LEN_W'($urandom_range(1, 4));
            default: len = spm_pkg::LEN_W'($urandom_range(5, PAT_MAX - 1));
        endcase
        start = $urandom_range(0, 5);
        for (i = 0; i < 6; i++)
        begin
            idx = spm_pkg::CFG_IDX_W'((start + i) % 6);
            case (idx)
                spm_pkg::REG_MATCH_MODE:
                    set_reg(idx, spm_pkg::WORD_W'($urandom_range(0, 3)));
                spm_pkg::REG_PATTERN_LENGTH:
                    set_reg(idx, spm_pkg::WORD_W'(len));
                default:
                    set_reg(idx, words[idx - spm_pkg::REG_PATTERN_WORD_0]);
            endcase
        end
        if ($urandom_range(0, 2) == 0)
            set_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                    {$urandom, $urandom});
        setting_count++;
    endtask

    // One random string: mostly built around the pattern so the matching
    // paths get exercised, the rest mutated copies, noise and long strings.
    task automatic make_string();
        int n;
        int kind;
        int head;
        int tail;
        int spot;
        int k;
        n = eff_len();
        draft.delete();
        kind = $urandom_range(0, 7);
        case (kind)
            0:
                for (k = 0; k < n; k++)
                    draft.push_back(pat_at(k));
            1, 2, 3:
            begin
                head = (kind == 1) ? 0 : $urandom_range(0, 5);
                tail = (kind == 2) ? 0 : $urandom_range(0, 5);
                repeat (head) draft.push_back(pick_sym());
                for (k = 0; k < n; k++)
                    draft.push_back(pat_at(k));
                repeat (tail) draft.push_back(pick_sym());
            end
            4:
            begin
                // near miss: one bit flipped, sometimes one byte dropped
                for (k = 0; k < n; k++)
                    draft.push_back(pat_at(k));
                if (n > 0)
                begin
                    spot = $urandom_range(0, n - 1);
                    if ($urandom_range(0, 2) == 0)
                        draft.delete(spot);
                    else
                        draft[spot] = draft[spot] ^ (8'h01 << $urandom_range(0, 7));
                end
            end
            5:
                repeat ($urandom_range(0, 12)) draft.push_back(pick_sym());
            6:
                repeat ($urandom_range(0, 12)) draft.push_back(8'($urandom));
            default:
            begin
                // long string, mostly long enough to run the byte count into saturation
                repeat ($urandom_range(30, 70)) draft.push_back(pick_sym());
                if (n > 0 && draft.size() >= n && $urandom_range(0, 1) == 0)
                begin
                    spot = $urandom_range(0, draft.size() - n);
                    for (k = 0; k < n; k++)
                        draft[spot + k] = pat_at(k);
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------
    initial
    begin : sequencer
        int k;
        in_ch.valid        = 1'b0;
        in_ch.text_byte    = '0;
        in_ch.empty_string = 1'b0;
        in_ch.string_end   = 1'b0;
        out_ch.ready       = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        for (k = 0; k < spm_pkg::PATTERN_WORDS; k++)
            cur_words[k] = '0;
        for (k = 0; k < PAT_MAX; k++)
            tail_win[k] = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset setting: prefix mode, empty pattern, so everything matches
        feed_text("ab");
        feed_text("");
        drain();

        // exact mode against "abc": equal, short, long
        set_reg(spm_pkg::REG_MATCH_MODE, spm_pkg::WORD_W'(spm_pkg::MODE_EXACT));
        set_reg(spm_pkg::REG_PATTERN_LENGTH, spm_pkg::WORD_W'(3));
        set_reg(spm_pkg::REG_PATTERN_WORD_0, 64'h0000_0000_0063_6261);
        feed_text("abc");
        feed_text("ab");
        feed_text("abcd");
        drain();

        // empty pattern in exact mode: only the zero-length string matches
        set_reg(spm_pkg::REG_PATTERN_LENGTH, spm_pkg::WORD_W'(0));
        feed_text("");
        feed_text("x");
        drain();

        // substring "aab" inside "aaab": needs the true contiguous test, with a
        // stray blank request in the middle; then a string closed by a blank request
        set_reg(spm_pkg::REG_MATCH_MODE, spm_pkg::WORD_W'(spm_pkg::MODE_SUBSTRING));
        set_reg(spm_pkg::REG_PATTERN_LENGTH, spm_pkg::WORD_W'(3));
        set_reg(spm_pkg::REG_PATTERN_WORD_0, 64'h0000_0000_0062_6161);
        push_req(8'h61, 1'b0, 1'b0);
        push_req(8'hFF, 1'b1, 1'b0);
        push_req(8'h61, 1'b0, 1'b0);
        push_req(8'h61, 1'b0, 1'b0);
        push_req(8'h62, 1'b0, 1'b1);
        push_req(8'h61, 1'b0, 1'b0);
        push_req(8'h00, 1'b1, 1'b1);
        drain();

        // suffix of extreme bytes; writes past the list must change nothing
        set_reg(spm_pkg::REG_MATCH_MODE, spm_pkg::WORD_W'(spm_pkg::MODE_SUFFIX));
        set_reg(spm_pkg::REG_PATTERN_LENGTH, spm_pkg::WORD_W'(2));
        set_reg(spm_pkg::REG_PATTERN_WORD_0, 64'h0000_0000_0000_00FF);
        set_reg(REG_SPARE_LO, 64'h0000_0000_0000_0001);
        set_reg(REG_SPARE_HI, '1);
        push_req(8'hFF, 1'b0, 1'b0);
        push_req(8'h00, 1'b0, 1'b1);
        drain();

        // random phases; every third one runs without idling
        k = 0;
        while (fed_items < TARGET)
        begin
            calm = (k % 3 == 2);
            setup_phase();
            repeat (12)
            begin
                make_string();
                feed_draft();
            end
            drain();
            k++;
        end

        calm = 1'b0;
        repeat (8) @(posedge clk);
        $display("covered %0d requests (%0d counted) over %0d random settings",
                 reqs_taken, fed_items, setting_count);
        $display("%0d strings checked, %0d matched, %0d mismatches, %0d results outstanding",
                 strings_checked, matched_count, mismatch_count, verdicts_due.size());
        if (mismatch_count == 0 && verdicts_due.size() == 0)
            $display("PASS string_pattern_matcher");
        else
            $display("FAIL string_pattern_matcher");
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial
    begin
        #10_000_000;
        $display("FAIL string_pattern_matcher");
        $finish;
    end

endmodule

/* string_pattern_matcher.f */
rtl/spm_pkg.sv
rtl/spm_ifs.sv
rtl/spm_cell.sv
rtl/spm_out_buf.sv
rtl/string_pattern_matcher.sv
rtl/spm_checker.sv
verif/tb.sv
